/* src/detector_channel_to_pixel_mapper_macros.svh */
// assertion macros for the detector channel to pixel mapper
// expects clk and rst_n in the scope of each use
`ifndef DETECTOR_CHANNEL_TO_PIXEL_MAPPER_MACROS_SVH
`define DETECTOR_CHANNEL_TO_PIXEL_MAPPER_MACROS_SVH

// same-cycle implication
`define DCPM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcpm same-cycle check failed");

// next-cycle implication
`define DCPM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcpm next-cycle check failed");

`endif

/* src/dcpm_pkg.sv */
// types, constants and connector rom for the detector channel to pixel mapper
// no dependencies
package dcpm_pkg;

    localparam logic [6:0]  LAST_CONNECTED    = 7'd117;
    localparam logic [6:0]  CHANNELS_PER_SLOT = 7'd108;
    localparam logic [11:0] COMPAND_KNEE      = 12'd256;
    localparam logic [6:0]  TOP_ROW           = 7'd71;
    localparam logic [3:0]  PIXELS_PER_PD     = 4'd6;
    localparam logic [5:0]  CONN_ENTRIES      = 6'd48;
    localparam logic [2:0]  ROM_X_MAX         = 3'd5;
    localparam logic [2:0]  ALL_FRAMES_GOOD   = 3'b111;
    localparam logic [3:0]  SEG_RECIP         = 4'd11;

    typedef enum logic [1:0] {
        CFG_OLD_BOARD       = 2'd0,
        CFG_ROTATION_S      = 2'd1,
        CFG_PHOTODETECTOR_X = 2'd2,
        CFG_DROP_BAD_FRAMES = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [6:0] raw_channel;
        logic       is_reordered;
        logic       is_sparse;
        logic [1:0] card_slot;
        logic [9:0] sample_one;
        logic [9:0] sample_two;
        logic [9:0] sample_three;
        logic [2:0] frame_flags;
    } in_item_t;

    typedef struct packed {
        logic [6:0]        chip_channel;
        logic signed [7:0] pixel_x;
        logic signed [7:0] pixel_y;
        logic [11:0]       amp_one;
        logic [11:0]       amp_two;
        logic [11:0]       amp_three;
        logic              good;
    } out_item_t;

    typedef struct packed {
        logic [6:0] chan;
        logic [1:0] slot;
        logic       conn;
    } loc_req_t;

    typedef struct packed {
        logic [2:0] rx;
        logic [6:0] ry;
        logic       conn;
    } loc_rsp_t;

    function automatic logic [2:0] rom_even_x(input logic [4:0] idx);
        logic [2:0] x;
        case (idx)
            5'd0:  x = 3'd3;  5'd1:  x = 3'd3;  5'd2:  x = 3'd4;  5'd3:  x = 3'd5;
            5'd4:  x = 3'd4;  5'd5:  x = 3'd3;  5'd6:  x = 3'd5;  5'd7:  x = 3'd4;
            5'd8:  x = 3'd5;  5'd9:  x = 3'd5;  5'd10: x = 3'd4;  5'd11: x = 3'd3;
            5'd12: x = 3'd3;  5'd13: x = 3'd4;  5'd14: x = 3'd5;  5'd15: x = 3'd5;
            5'd16: x = 3'd4;  5'd17: x = 3'd5;  5'd18: x = 3'd3;  5'd19: x = 3'd4;
            5'd20: x = 3'd5;  5'd21: x = 3'd4;  5'd22: x = 3'd3;  5'd23: x = 3'd3;
            default: x = 3'd0;
        endcase
        return x;
    endfunction

    function automatic logic [2:0] rom_even_y(input logic [4:0] idx);
        logic [2:0] y;
        case (idx)
            5'd0:  y = 3'd0;  5'd1:  y = 3'd1;  5'd2:  y = 3'd0;  5'd3:  y = 3'd0;
            5'd4:  y = 3'd1;  5'd5:  y = 3'd2;  5'd6:  y = 3'd1;  5'd7:  y = 3'd2;
            5'd8:  y = 3'd2;  5'd9:  y = 3'd3;  5'd10: y = 3'd3;  5'd11: y = 3'd3;
            5'd12: y = 3'd4;  5'd13: y = 3'd4;  5'd14: y = 3'd4;  5'd15: y = 3'd5;
            5'd16: y = 3'd5;  5'd17: y = 3'd6;  5'd18: y = 3'd5;  5'd19: y = 3'd6;
            5'd20: y = 3'd7;  5'd21: y = 3'd7;  5'd22: y = 3'd6;  5'd23: y = 3'd7;
            default: y = 3'd0;
        endcase
        return y;
    endfunction

    function automatic logic [11:0] compand(input logic [10:0] a);
        logic [11:0] wide;
        wide = {1'b0, a};
        return (wide < COMPAND_KNEE) ? wide : ({a, 1'b0} - COMPAND_KNEE);
    endfunction

endpackage

/* src/dcpm_locate.sv */
// two-stage connector lookup: segment and rom entry to rom x and row
// depends on dcpm_pkg
module dcpm_locate
(
    input  logic              clk,
    input  dcpm_pkg::loc_req_t req,
    output dcpm_pkg::loc_rsp_t rsp
);

    logic [8:0]           pos_next;
    logic [8:0]           pos_reg;
    logic                 conn_reg;
    logic [8:0]           quot_prod;
    logic [3:0]           seg;
    logic [8:0]           seg_base;
    logic [5:0]           ent;
    logic [2:0]           x_even;
    dcpm_pkg::loc_rsp_t   rsp_next;
    dcpm_pkg::loc_rsp_t   rsp_reg;

    // position within the card
    always_comb
    begin
        pos_next = 9'(req.slot) * 9'(dcpm_pkg::CHANNELS_PER_SLOT) + 9'(req.chan);
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        conn_reg <= req.conn;
    end

    // divide by 48 as (pos / 16) / 3, third taken by reciprocal
    always_comb
    begin
        quot_prod     = 9'(pos_reg[8:4]) * 9'(dcpm_pkg::SEG_RECIP);
        seg           = quot_prod[8:5];
        seg_base      = 9'(seg) * 9'(dcpm_pkg::CONN_ENTRIES);
        ent           = 6'(pos_reg - seg_base);
        x_even        = dcpm_pkg::rom_even_x(ent[5:1]);
        rsp_next.rx   = ent[0] ? (dcpm_pkg::ROM_X_MAX - x_even) : x_even;
        rsp_next.ry   = {seg[3:0], dcpm_pkg::rom_even_y(ent[5:1])};
        rsp_next.conn = conn_reg;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

/* src/detector_channel_to_pixel_mapper.sv */
// top level of the detector channel to pixel mapper: config registers, pipeline, output
// depends on dcpm_pkg, dcpm_locate and the assertion macro header
//
// Takes one channel sample per clock, every clock, once busy has dropped after
// reset; there is no clearing pass. Four register stages: channel reorder and
// amplitude decode, card position, connector rom lookup, pixel placement. A result
// is strobed on done for one cycle, four cycles after its start, and must be taken
// then. Samples with bad frame flags give no result while drop_bad_frames is set.
// Write configuration only while no transaction is in flight.
`include "detector_channel_to_pixel_mapper_macros.svh"

module detector_channel_to_pixel_mapper
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dcpm_pkg::in_item_t  item,
    output logic                done,
    output dcpm_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data
);

    logic       busy_reg;
    logic       old_board_reg;
    logic       rotation_s_reg;
    logic [3:0] photodetector_x_reg;
    logic       drop_bad_frames_reg;

    logic        accept;
    logic        good_next;
    logic        v1_next;
    logic [6:0]  chan_next;
    logic [6:0]  mapped;
    logic        conn_next;
    logic [11:0] amp1_next;
    logic [11:0] amp2_next;
    logic [11:0] amp3_next;

    logic        v1_reg, v2_reg, v3_reg, done_reg;
    logic [6:0]  chan1_reg, chan2_reg, chan3_reg;
    logic [6:0]  mapped1_reg;
    logic [1:0]  slot1_reg;
    logic        conn1_reg;
    logic [11:0] amp1_1_reg, amp2_1_reg, amp3_1_reg;
    logic [11:0] amp1_2_reg, amp2_2_reg, amp3_2_reg;
    logic [11:0] amp1_3_reg, amp2_3_reg, amp3_3_reg;
    logic        good1_reg, good2_reg, good3_reg;

    dcpm_pkg::loc_req_t  loc_req;
    dcpm_pkg::loc_rsp_t  loc_rsp;
    logic [6:0]          pd_offset;
    dcpm_pkg::out_item_t result_next;
    dcpm_pkg::out_item_t result_reg;

    logic drop_check;
    logic x_unconn;
    logic x_in_range;

    // ready once out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_board_reg       <= 1'b0;
            rotation_s_reg      <= 1'b0;
            photodetector_x_reg <= 4'd0;
            drop_bad_frames_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dcpm_pkg::cfg_index_t'(cfg_index))
                dcpm_pkg::CFG_OLD_BOARD:       old_board_reg       <= cfg_data[0];
                dcpm_pkg::CFG_ROTATION_S:      rotation_s_reg      <= cfg_data[0];
                dcpm_pkg::CFG_PHOTODETECTOR_X: photodetector_x_reg <= cfg_data;
                dcpm_pkg::CFG_DROP_BAD_FRAMES: drop_bad_frames_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: reorder, reverse, cut, decode amplitudes
    always_comb
    begin
        accept    = start && !busy_reg;
        good_next = (item.frame_flags == dcpm_pkg::ALL_FRAMES_GOOD);
        v1_next   = accept && (good_next || !drop_bad_frames_reg);
        chan_next = item.is_reordered ? item.raw_channel
                  : {item.raw_channel[1:0], item.raw_channel[3:2], item.raw_channel[6:4]};
        if (old_board_reg)
        begin
            mapped    = chan_next;
            conn_next = (chan_next < dcpm_pkg::CHANNELS_PER_SLOT);
        end
        else
        begin
            mapped    = dcpm_pkg::LAST_CONNECTED - chan_next;
            conn_next = (chan_next <= dcpm_pkg::LAST_CONNECTED) &&
                        (mapped < dcpm_pkg::CHANNELS_PER_SLOT);
        end
        if (item.is_sparse)
        begin
            amp1_next = dcpm_pkg::compand({item.sample_one, 1'b0});
            amp2_next = dcpm_pkg::compand({item.sample_two, 1'b0});
            amp3_next = dcpm_pkg::compand({1'b0, item.sample_three});
        end
        else
        begin
            amp1_next = {2'b00, item.sample_one};
            amp2_next = {2'b00, item.sample_two};
            amp3_next = {2'b00, item.sample_three};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        chan1_reg   <= chan_next;
        mapped1_reg <= mapped;
        slot1_reg   <= item.card_slot;
        conn1_reg   <= conn_next;
        amp1_1_reg  <= amp1_next;
        amp2_1_reg  <= amp2_next;
        amp3_1_reg  <= amp3_next;
        good1_reg   <= good_next;
        chan2_reg   <= chan1_reg;
        amp1_2_reg  <= amp1_1_reg;
        amp2_2_reg  <= amp2_1_reg;
        amp3_2_reg  <= amp3_1_reg;
        good2_reg   <= good1_reg;
        chan3_reg   <= chan2_reg;
        amp1_3_reg  <= amp1_2_reg;
        amp2_3_reg  <= amp2_2_reg;
        amp3_3_reg  <= amp3_2_reg;
        good3_reg   <= good2_reg;
    end

    // stages 2 and 3: connector lookup
    assign loc_req.chan = mapped1_reg;
    assign loc_req.slot = slot1_reg;
    assign loc_req.conn = conn1_reg;

    dcpm_locate u_locate
    (
        .clk (clk),
        .req (loc_req),
        .rsp (loc_rsp)
    );

    // stage 4: flips and photodetector offset
    always_comb
    begin
        pd_offset                = 7'(photodetector_x_reg) * 7'(dcpm_pkg::PIXELS_PER_PD);
        result_next.chip_channel = chan3_reg;
        result_next.amp_one      = amp1_3_reg;
        result_next.amp_two      = amp2_3_reg;
        result_next.amp_three    = amp3_3_reg;
        result_next.good         = good3_reg;
        if (!loc_rsp.conn)
        begin
            result_next.pixel_x = 8'hFF;
            result_next.pixel_y = 8'hFF;
        end
        else if (rotation_s_reg)
        begin
            result_next.pixel_x = 8'(7'(loc_rsp.rx) + pd_offset);
            result_next.pixel_y = 8'(dcpm_pkg::TOP_ROW - loc_rsp.ry);
        end
        else
        begin
            result_next.pixel_x = 8'(7'(dcpm_pkg::ROM_X_MAX - loc_rsp.rx) + pd_offset);
            result_next.pixel_y = 8'(loc_rsp.ry);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    assign drop_check = accept && drop_bad_frames_reg && !good_next;
    assign x_unconn   = (result_reg.pixel_x == 8'hFF);
    assign x_in_range = !result_reg.pixel_x[7] && (result_reg.pixel_x[6:0] <= 7'd95);

    `DCPM_ASSERT_NEXT(a_drop_bad, drop_check, !v1_reg)
    `DCPM_ASSERT_NEXT(a_flow, v3_reg, done_reg)
    `DCPM_ASSERT_NOW(a_unconn_pair, done_reg && x_unconn, result_reg.pixel_y == 8'hFF)
    `DCPM_ASSERT_NOW(a_x_range, done_reg, x_unconn || x_in_range)
    `DCPM_ASSERT_NOW(a_good_kept, done_reg && !result_reg.good, !drop_bad_frames_reg)

endmodule

/* sim/tb_detector_channel_to_pixel_mapper.sv */
// testbench for the detector channel to pixel mapper: directed and random channel samples
// over several register settings, each result checked against a predicted pixel and amplitudes
// depends on dcpm_pkg and detector_channel_to_pixel_mapper
module tb_detector_channel_to_pixel_mapper;
    import dcpm_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 115;

    class pixel_map_scoreboard;
        out_item_t   expected_pixels[$];
        int          errors;
        bit          old_board;
        bit          rotation_s;
        bit          drop_bad;
        logic [3:0]  pd_column;
        int unsigned conn_x[24] = '{3, 3, 4, 5, 4, 3, 5, 4, 5, 5, 4, 3,
                                    3, 4, 5, 5, 4, 5, 3, 4, 5, 4, 3, 3};
        int unsigned conn_y[24] = '{0, 1, 0, 0, 1, 2, 1, 2, 2, 3, 3, 3,
                                    4, 4, 4, 5, 5, 6, 5, 6, 7, 7, 6, 7};

        function new();
            errors     = 0;
            old_board  = 1'b0;
            rotation_s = 1'b0;
            drop_bad   = 1'b0;
            pd_column  = 4'd0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_reg(cfg_index_t idx, logic [3:0] value);
            case (idx)
                CFG_OLD_BOARD:       old_board  = value[0];
                CFG_ROTATION_S:      rotation_s = value[0];
                CFG_PHOTODETECTOR_X: pd_column  = value;
                CFG_DROP_BAD_FRAMES: drop_bad   = value[0];
                default:             ;
            endcase
        endfunction

        function int unsigned decode_sparse(int unsigned a);
            return (a < COMPAND_KNEE) ? a : 2 * a - COMPAND_KNEE;
        endfunction

        function void note_input(in_item_t it);
            out_item_t   r;
            logic [6:0]  ch;
            int unsigned m;
            int unsigned p;
            int unsigned seg;
            int unsigned ent;
            int unsigned x;
            int unsigned y;
            int unsigned px;
            int unsigned py;
            bit          conn;
            r.good = (it.frame_flags == ALL_FRAMES_GOOD);
            if (!r.good && drop_bad)
                return;
            ch = it.is_reordered ? it.raw_channel :
                 {it.raw_channel[1:0], it.raw_channel[3:2], it.raw_channel[6:4]};
            m    = ch;
            conn = 1'b1;
            if (!old_board)
            begin
                if (ch > LAST_CONNECTED)
                    conn = 1'b0;
                else
                    m = LAST_CONNECTED - ch;
            end
            if (m >= CHANNELS_PER_SLOT)
                conn = 1'b0;
            if (conn)
            begin
                p   = it.card_slot * CHANNELS_PER_SLOT + m;
                seg = p / CONN_ENTRIES;
                ent = p % CONN_ENTRIES;
                x   = conn_x[ent / 2];
                if (ent % 2)
                    x = ROM_X_MAX - x;
                y = conn_y[ent / 2] + seg * 8;
                if (rotation_s)
                begin
                    px = x + pd_column * PIXELS_PER_PD;
                    py = TOP_ROW - y;
                end
                else
                begin
                    px = ROM_X_MAX - x + pd_column * PIXELS_PER_PD;
                    py = y;
                end
                r.pixel_x = 8'(px);
                r.pixel_y = 8'(py);
            end
            else
            begin
                r.pixel_x = -8'sd1;
                r.pixel_y = -8'sd1;
            end
            r.chip_channel = ch;
            if (it.is_sparse)
            begin
                r.amp_one   = 12'(decode_sparse(2 * it.sample_one));
                r.amp_two   = 12'(decode_sparse(2 * it.sample_two));
                r.amp_three = 12'(decode_sparse(it.sample_three));
            end
            else
            begin
                r.amp_one   = {2'b00, it.sample_one};
                r.amp_two   = {2'b00, it.sample_two};
                r.amp_three = {2'b00, it.sample_three};
            end
            expected_pixels = {expected_pixels, r};
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("result with no transaction waiting: %h", got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("chip_channel", want.chip_channel, got.chip_channel);
            compare_field("pixel_x", $signed(want.pixel_x), $signed(got.pixel_x));
            compare_field("pixel_y", $signed(want.pixel_y), $signed(got.pixel_y));
            compare_field("amp_one", want.amp_one, got.amp_one);
            compare_field("amp_two", want.amp_two, got.amp_two);
            compare_field("amp_three", want.amp_three, got.amp_three);
            compare_field("good", want.good, got.good);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    in_item_t    item      = '0;
    logic        done;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [3:0]  cfg_data  = 4'd0;

    pixel_map_scoreboard sb;
    int                  quiet_cycles = 0;

    detector_channel_to_pixel_mapper u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic in_item_t sample_of(logic [6:0] raw, bit reo, bit sparse,
                                           logic [1:0] slot, logic [9:0] s1,
                                           logic [9:0] s2, logic [9:0] s3,
                                           logic [2:0] flags);
        in_item_t it;
        it.raw_channel  = raw;
        it.is_reordered = reo;
        it.is_sparse    = sparse;
        it.card_slot    = slot;
        it.sample_one   = s1;
        it.sample_two   = s2;
        it.sample_three = s3;
        it.frame_flags  = flags;
        return it;
    endfunction

    function automatic logic [9:0] pick_amplitude();
        case ($urandom_range(0, 7))
            0:       return 10'($urandom_range(126, 130));
            1:       return 10'($urandom_range(254, 258));
            2:       return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_sample();
        in_item_t it;
        case ($urandom_range(0, 7))
            0:       it.raw_channel = 7'($urandom_range(105, 120));
            1:       it.raw_channel = $urandom_range(0, 1) ? 7'd0 : 7'd127;
            default: it.raw_channel = 7'($urandom);
        endcase
        it.is_reordered = 1'($urandom);
        it.is_sparse    = 1'($urandom);
        it.card_slot    = 2'($urandom);
        it.sample_one   = pick_amplitude();
        it.sample_two   = pick_amplitude();
        it.sample_three = pick_amplitude();
        it.frame_flags  = ($urandom_range(0, 3) != 0) ? ALL_FRAMES_GOOD : 3'($urandom);
        return it;
    endfunction

    task automatic send_sample(in_item_t it, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_input(it);
    endtask

    // idle until every result is in, then let dropped samples clear the pipeline
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup(bit ob, bit rs, logic [3:0] pdx, bit db);
        logic [3:0] value;
        cfg_index_t idx;
        int         i;
        settle();
        for (i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            case (idx)
                CFG_OLD_BOARD:       value = {3'($urandom), ob};
                CFG_ROTATION_S:      value = {3'($urandom), rs};
                CFG_PHOTODETECTOR_X: value = pdx;
                default:             value = {3'($urandom), db};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(idx, value);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int n;
        int gap;
        bit burst;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        load_setup(1'b0, 1'b0, 4'd0, 1'b0);
        send_sample(sample_of(7'd0, 1, 0, 2'd0, 10'd0, 10'd0, 10'd0, 3'd7), 0);
        send_sample(sample_of(7'd117, 1, 0, 2'd3, 10'd1023, 10'd1023, 10'd1023, 3'd7), 0);
        send_sample(sample_of(7'd118, 1, 0, 2'd1, 10'd512, 10'd256, 10'd255, 3'd7), 0);
        send_sample(sample_of(7'd127, 1, 1, 2'd2, 10'd1023, 10'd1023, 10'd1023, 3'd7), 2);
        send_sample(sample_of(7'd127, 0, 1, 2'd3, 10'd0, 10'd0, 10'd0, 3'd7), 0);
        send_sample(sample_of(7'd0, 0, 1, 2'd0, 10'd127, 10'd128, 10'd255, 3'd7), 0);
        send_sample(sample_of(7'd1, 0, 1, 2'd1, 10'd129, 10'd1, 10'd256, 3'd7), 1);
        send_sample(sample_of(7'd16, 0, 0, 2'd2, 10'h2aa, 10'h155, 10'h3ff, 3'd0), 0);
        send_sample(sample_of(7'd42, 1, 1, 2'd3, 10'h155, 10'h2aa, 10'd257, 3'd6), 0);
        send_sample(sample_of(7'd85, 0, 0, 2'd0, 10'd300, 10'd600, 10'd900, 3'd3), 3);
        send_sample(sample_of(7'd10, 1, 0, 2'd3, 10'd1, 10'd2, 10'd3, 3'd5), 0);
        send_sample(sample_of(7'd63, 0, 1, 2'd1, 10'd511, 10'd512, 10'd513, 3'd7), 0);

        // old board wiring, s rotation, last column, bad frames dropped
        load_setup(1'b1, 1'b1, 4'd15, 1'b1);
        send_sample(sample_of(7'd107, 1, 0, 2'd3, 10'd7, 10'd8, 10'd9, 3'd7), 0);
        send_sample(sample_of(7'd108, 1, 0, 2'd0, 10'd1023, 10'd0, 10'd1023, 3'd7), 0);
        send_sample(sample_of(7'd127, 1, 1, 2'd2, 10'd1023, 10'd1023, 10'd1023, 3'd7), 0);
        send_sample(sample_of(7'd0, 1, 0, 2'd0, 10'd0, 10'd0, 10'd0, 3'd7), 0);
        send_sample(sample_of(7'd5, 0, 1, 2'd1, 10'd200, 10'd300, 10'd400, 3'd0), 0);
        send_sample(sample_of(7'd20, 1, 0, 2'd2, 10'd11, 10'd22, 10'd33, 3'd6), 0);
        send_sample(sample_of(7'd33, 0, 1, 2'd3, 10'd1023, 10'd0, 10'd1023, 3'd7), 0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       load_setup(1'b0, 1'b0, 4'd0, 1'b0);
                1:       load_setup(1'b1, 1'b1, 4'd15, 1'b1);
                2:       load_setup(1'b0, 1'b1, 4'd15, 1'b0);
                3:       load_setup(1'b1, 1'b0, 4'd0, 1'b1);
                default: load_setup(1'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
            endcase
            burst = 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    settle();
                gap = burst ? 0 : $urandom_range(0, 11);
                send_sample(random_sample(), gap);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
